FILE: rtl/core/checksummed_frame_builder_defines.svh
// ----------------------------------------------------------------------------
// Checksummed frame builder assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_BUILDER_DEFINES_SVH
`define CHECKSUMMED_FRAME_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS

// Check prop on every clk edge while arst_n is high.
`define CFB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check prop on every clk edge, during reset too.
`define CFB_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CFB_ASSERT(name, prop, msg)
`define CFB_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: rtl/core/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants of the checksummed frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int MAX_PAYLOAD    = 1024;
	localparam int FRAME_OVERHEAD = 6;
	localparam int RUN_MAX        = 6;
	localparam int CNT_W          = $clog2(RUN_MAX + 1);
	localparam int ADDR_W         = 3;

	// Item kind carried on the input tuser bit
	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_PAYLOAD = 1'b1
	} action_t;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_END_CODE     = 1'b0,
		REG_BUFFER_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  end_code;
		logic [15:0] buffer_limit;
	} cfg_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  start_code;
		logic [7:0]  op_code;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} item_t;

	// One run of results: byte 0 goes out first
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    rej;
		logic                    tail;
	} run_t;

endpackage

FILE: rtl/core/cfb_regs.sv
// ----------------------------------------------------------------------------
// cfb_regs
// APB register file: end code and buffer limit.
// ----------------------------------------------------------------------------
module cfb_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cfb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output cfb_pkg::cfg_t             cfg
);

	cfb_pkg::cfg_t    cfg_q;
	cfb_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = cfb_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_code     <= 8'h00;
			cfg_q.buffer_limit <= 16'hFFFF;
		end else if (wr_en) begin
			unique case (idx)
				cfb_pkg::REG_END_CODE:     cfg_q.end_code     <= pwdata[7:0];
				cfb_pkg::REG_BUFFER_LIMIT: cfg_q.buffer_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cfb_pkg::REG_END_CODE:     prdata = {24'h0, cfg_q.end_code};
			cfb_pkg::REG_BUFFER_LIMIT: prdata = {16'h0, cfg_q.buffer_limit};
			default:                   prdata = 32'h0;
		endcase
	end

endmodule

FILE: rtl/core/cfb_decode.sv
// ----------------------------------------------------------------------------
// cfb_decode
// Input register, frame state and the decode of one item into a result run.
// ----------------------------------------------------------------------------
`include "checksummed_frame_builder_defines.svh"

module cfb_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cfb_pkg::item_t      in_item,
	input  cfb_pkg::cfg_t       cfg,
	input  logic                run_ready,
	output logic                run_valid,
	output cfb_pkg::run_t       run
);

	cfb_pkg::item_t item_s1;
	logic           valid_s1;

	logic        open_q;
	logic [15:0] rem_q;
	logic [7:0]  sum_q;

	logic        open_d;
	logic [15:0] rem_d;
	logic [7:0]  sum_d;

	logic [16:0] total;
	logic        bad_len;
	logic [15:0] len_field;
	logic [7:0]  hdr_sum;
	logic [7:0]  pay_sum;
	logic [15:0] rem_dec;

	assign run_valid = valid_s1 && run_ready;
	assign in_ready  = !valid_s1 || run_ready;

	// Input register: hold while the emitter is still busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= 16'h0;
			sum_q  <= 8'h0;
		end else if (run_valid) begin
			open_q <= open_d;
			rem_q  <= rem_d;
			sum_q  <= sum_d;
		end
	end

	assign total     = 17'(item_s1.payload_length) + 17'(cfb_pkg::FRAME_OVERHEAD);
	assign bad_len   = (item_s1.payload_length > 16'(cfb_pkg::MAX_PAYLOAD))
		|| (total > {1'b0, cfg.buffer_limit});
	assign len_field = item_s1.payload_length + 16'd1;
	assign hdr_sum   = len_field[15:8] + len_field[7:0] + item_s1.op_code;
	assign pay_sum   = sum_q + item_s1.data_byte;
	assign rem_dec   = rem_q - 16'd1;

	always_comb begin
		open_d    = open_q;
		rem_d     = rem_q;
		sum_d     = sum_q;
		run       = '0;
		run.cnt   = cfb_pkg::CNT_W'(1);
		case (item_s1.action)
			cfb_pkg::ACT_START: begin
				if (bad_len) begin
					open_d  = 1'b0;
					rem_d   = 16'h0;
					sum_d   = 8'h0;
					run.rej = 1'b1;
				end else begin
					run.bytes[0] = item_s1.start_code;
					run.bytes[1] = len_field[15:8];
					run.bytes[2] = len_field[7:0];
					run.bytes[3] = item_s1.op_code;
					sum_d        = hdr_sum;
					if (item_s1.payload_length == 16'h0) begin
						// Empty payload: close the frame in the same run
						run.bytes[4] = 8'h0 - hdr_sum;
						run.bytes[5] = cfg.end_code;
						run.cnt      = cfb_pkg::CNT_W'(6);
						run.tail     = 1'b1;
						open_d       = 1'b0;
						rem_d        = 16'h0;
					end else begin
						run.cnt = cfb_pkg::CNT_W'(4);
						open_d  = 1'b1;
						rem_d   = item_s1.payload_length;
					end
				end
			end
			default: begin
				if (!open_q || rem_q == 16'h0) begin
					open_d  = 1'b0;
					run.rej = 1'b1;
				end else begin
					run.bytes[0] = item_s1.data_byte;
					sum_d        = pay_sum;
					rem_d        = rem_dec;
					if (rem_dec == 16'h0) begin
						run.bytes[1] = 8'h0 - pay_sum;
						run.bytes[2] = cfg.end_code;
						run.cnt      = cfb_pkg::CNT_W'(3);
						run.tail     = 1'b1;
						open_d       = 1'b0;
					end
				end
			end
		endcase
	end

	`CFB_ASSERT(a_open_has_rem, open_q |-> (rem_q != 16'h0), "open frame with no bytes left")
	`CFB_ASSERT(a_s1_hold, (valid_s1 && !run_ready) |=> (valid_s1 && $stable(item_s1)),
		"stalled item lost")
	`CFB_ASSERT(a_run_cnt, run_valid |-> ((run.cnt != '0) && (run.cnt <= cfb_pkg::CNT_W'(6))),
		"run length out of range")

endmodule

FILE: rtl/core/cfb_emit.sv
// ----------------------------------------------------------------------------
// cfb_emit
// Result register: shifts one run out a byte per transfer.
// ----------------------------------------------------------------------------
`include "checksummed_frame_builder_defines.svh"

module cfb_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          run_valid,
	input  cfb_pkg::run_t run,
	output logic          run_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          out_frame_end,
	output logic          out_rejected
);

	logic                            valid_q;
	logic [cfb_pkg::RUN_MAX-1:0][7:0] bytes_q;
	logic [cfb_pkg::CNT_W-1:0]       cnt_q;
	logic                            rej_q;
	logic                            tail_q;
	logic                            last;

	assign last          = (cnt_q == cfb_pkg::CNT_W'(1));
	assign run_ready     = !valid_q || (out_ready && last);
	assign out_valid     = valid_q;
	assign out_byte      = bytes_q[0];
	assign out_last      = last;
	assign out_frame_end = tail_q && last;
	assign out_rejected  = rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (run_ready) begin
			valid_q <= run_valid;
			cnt_q   <= run.cnt;
		end else if (out_ready) begin
			cnt_q <= cnt_q - cfb_pkg::CNT_W'(1);
		end
	end

	// Advance to the next byte on each transfer, load a new run when drained
	always_ff @(posedge clk) begin
		if (run_ready) begin
			bytes_q <= run.bytes;
			rej_q   <= run.rej;
			tail_q  <= run.tail;
		end else if (out_ready) begin
			bytes_q <= bytes_q >> 8;
		end
	end

	`CFB_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !valid_q, "output valid during reset")
	`CFB_ASSERT(a_cnt_live, valid_q |-> (cnt_q != '0), "valid run with zero count")
	`CFB_ASSERT(a_load, (run_ready && run_valid) |=> (valid_q && cnt_q == $past(run.cnt)),
		"run not loaded")

endmodule

FILE: rtl/core/checksummed_frame_builder.sv
// ----------------------------------------------------------------------------
// checksummed_frame_builder
// Serial frame builder with length header and two's complement checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: a start item (tuser 0) carries start code, opcode
//   and payload length; a payload item (tuser 1) carries one data byte.
//   Output stream m_axis: one frame byte per transfer. tlast marks the final
//   byte caused by an input item; tuser flags the frame tail and rejects.
//   A start emits start code, 1+length (big-endian) and opcode; the last
//   payload byte is followed by the checksum and the end code. Bad lengths
//   and stray payload bytes give a single rejected byte of zero.
//   The first result of an item passes the input register, then the result
//   register. Throughput: one result per cycle while m_axis_tready is high;
//   a single-result item (a payload byte that does not end the frame, or a
//   reject) is taken every cycle, and an item with more results holds the
//   result register until it has sent them all.
//   When m_axis_tready is low the result register holds and s_axis_tready
//   drops once the input register is full as well.
//   Reset clears the frame state and both valid flags; end_code resets to
//   0 and buffer_limit to 65535. Write registers over APB only while idle.
// ----------------------------------------------------------------------------
module checksummed_frame_builder (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cfb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// Input stream
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// [7:0] start_code, [15:8] op_code, [31:16] payload_length, [39:32] data_byte
	input  logic [39:0]               s_axis_tdata,
	// [0] action
	input  logic                      s_axis_tuser,
	// Output stream
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]                m_axis_tdata,
	// last_in_run
	output logic                      m_axis_tlast,
	// [0] frame_end, [1] rejected
	output logic [1:0]                m_axis_tuser
);

	cfb_pkg::cfg_t  cfg;
	cfb_pkg::item_t in_item;
	cfb_pkg::run_t  run;
	logic           run_valid;
	logic           run_ready;
	logic           frame_end;
	logic           rejected;

	// Unpack the input transfer into item fields
	assign in_item.action         = cfb_pkg::action_t'(s_axis_tuser);
	assign in_item.start_code     = s_axis_tdata[7:0];
	assign in_item.op_code        = s_axis_tdata[15:8];
	assign in_item.payload_length = s_axis_tdata[31:16];
	assign in_item.data_byte      = s_axis_tdata[39:32];

	assign m_axis_tuser = {rejected, frame_end};

	cfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Hold the item, track the open frame and build its result run
	cfb_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.cfg       (cfg),
		.run_ready (run_ready),
		.run_valid (run_valid),
		.run       (run)
	);

	// Drain the run one byte per output transfer
	cfb_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.run_valid     (run_valid),
		.run           (run),
		.run_ready     (run_ready),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.out_last      (m_axis_tlast),
		.out_frame_end (frame_end),
		.out_rejected  (rejected)
	);

endmodule
